// ----- rtl/core/utf8d_pkg.sv -----
// shared types, constants and lookup functions for the utf-8 stream decoder
package utf8d_pkg;

    localparam int unsigned C_CP_W      = 21;
    localparam int unsigned C_CNT_W     = 3;
    localparam int unsigned C_Q_DEPTH   = 4;
    localparam int unsigned C_Q_PTR_W   = 2;

    localparam logic [C_CP_W-1:0] C_REPL_CP  = 21'h00FFFD;
    localparam logic [C_CP_W-1:0] C_MAX_CP   = 21'h10FFFF;
    localparam logic [C_CP_W-1:0] C_SURR_LO  = 21'h00D800;
    localparam logic [C_CP_W-1:0] C_SURR_HI  = 21'h00DFFF;
    localparam logic [5:0]        C_CONT_MASK = 6'h3F;
    localparam logic [1:0]        C_CONT_TAG  = 2'b10;

    // lead byte class codes
    localparam logic [2:0] C_LEN_BAD   = 3'd0;
    localparam logic [2:0] C_LEN_ASCII = 3'd1;
    localparam logic [2:0] C_LEN_TWO   = 3'd2;
    localparam logic [2:0] C_LEN_THREE = 3'd3;
    localparam logic [2:0] C_LEN_FOUR  = 3'd4;

    // one queue entry: replacements to flush, then an optional trailing result
    typedef struct packed {
        logic [C_CNT_W-1:0] flush_cnt;
        logic               has_tail;
        logic [C_CP_W-1:0]  tail_cp;
        logic               tail_bad;
        logic               fin;
    } t_job;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80)      len = C_LEN_ASCII;
        else if (b < 8'hC0) len = C_LEN_BAD;
        else if (b < 8'hE0) len = C_LEN_TWO;
        else if (b < 8'hF0) len = C_LEN_THREE;
        else if (b < 8'hF8) len = C_LEN_FOUR;
        else                len = C_LEN_BAD;
        return len;
    endfunction

    function automatic logic [C_CP_W-1:0] lead_bits(input logic [7:0] b,
                                                    input logic [2:0] len);
        logic [C_CP_W-1:0] v;
        unique case (len)
            C_LEN_TWO:   v = {16'd0, b[4:0]};
            C_LEN_THREE: v = {17'd0, b[3:0]};
            C_LEN_FOUR:  v = {18'd0, b[2:0]};
            default:     v = {13'd0, b};
        endcase
        return v;
    endfunction

    function automatic logic [C_CP_W-1:0] least_cp(input logic [2:0] len);
        logic [C_CP_W-1:0] v;
        unique case (len)
            C_LEN_TWO:   v = 21'h000080;
            C_LEN_THREE: v = 21'h000800;
            C_LEN_FOUR:  v = 21'h010000;
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/utf8d_front.sv -----
// front end: accepts bytes, tracks the pending sequence and builds result jobs
module utf8d_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_final,
    input  logic                  i_full,
    output logic                  o_push,
    output utf8d_pkg::t_job       o_job
);
    import utf8d_pkg::*;

    logic [2:0]        r_exp;
    logic [1:0]        r_held;
    logic [C_CP_W-1:0] r_part;
    logic [2:0]        n_exp;
    logic [1:0]        n_held;
    logic [C_CP_W-1:0] n_part;

    logic              accept;
    logic              pending;
    logic              is_cont;
    logic [1:0]        held_inc;
    logic [C_CP_W-1:0] cont_part;
    logic              cp_bad;
    logic [2:0]        len;
    logic              fresh;
    logic [C_CNT_W-1:0] flush_pre;
    t_job              job;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign pending   = (r_exp != 3'd0);
    assign is_cont   = (i_byte[7:6] == C_CONT_TAG);
    assign held_inc  = r_held + 2'd1;
    assign cont_part = {r_part[C_CP_W-7:0], i_byte[5:0] & C_CONT_MASK};
    assign len       = lead_length(i_byte);
    assign cp_bad    = (cont_part > C_MAX_CP)
                    || ((cont_part >= C_SURR_LO) && (cont_part <= C_SURR_HI))
                    || (cont_part < least_cp(r_exp));

    always_comb begin
        n_exp     = r_exp;
        n_held    = r_held;
        n_part    = r_part;
        fresh     = 1'b1;
        flush_pre = '0;
        job       = '0;
        job.tail_cp = C_REPL_CP;
        if (pending) begin
            if (is_cont) begin
                fresh  = 1'b0;
                n_part = cont_part;
                n_held = held_inc;
                if ((3'(held_inc) + 3'd1) >= r_exp) begin
                    // sequence complete
                    job.has_tail = 1'b1;
                    job.tail_bad = cp_bad;
                    job.tail_cp  = cp_bad ? C_REPL_CP : cont_part;
                    n_exp  = '0;
                    n_held = '0;
                    n_part = '0;
                end else if (i_final) begin
                    // cut at end of string
                    job.flush_cnt = 3'(held_inc) + 3'd1;
                end
            end else begin
                // missing continuation, byte decoded anew below
                flush_pre = 3'(r_held) + 3'd1;
                n_exp  = '0;
                n_held = '0;
                n_part = '0;
            end
        end
        if (fresh) begin
            job.flush_cnt = flush_pre;
            if (len == C_LEN_ASCII) begin
                job.has_tail = 1'b1;
                job.tail_cp  = {13'd0, i_byte};
            end else if (len == C_LEN_BAD) begin
                job.has_tail = 1'b1;
                job.tail_bad = 1'b1;
            end else begin
                n_exp  = len;
                n_held = '0;
                n_part = lead_bits(i_byte, len);
                if (i_final) job.flush_cnt = flush_pre + 3'd1;
            end
        end
        if (i_final) begin
            n_exp  = '0;
            n_held = '0;
            n_part = '0;
        end
        job.fin = i_final;
    end

    assign o_job  = job;
    assign o_push = accept && ((job.flush_cnt != '0) || job.has_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= '0;
            r_held <= '0;
            r_part <= '0;
        end else if (accept) begin
            r_exp  <= n_exp;
            r_held <= n_held;
            r_part <= n_part;
        end
    end

endmodule

// ----- rtl/core/utf8d_queue.sv -----
// small job queue between the front end and the result sequencer
module utf8d_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utf8d_pkg::t_job  i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output utf8d_pkg::t_job  o_job
);
    import utf8d_pkg::*;

    t_job                 r_mem [C_Q_DEPTH];
    logic [C_Q_PTR_W-1:0] r_wr;
    logic [C_Q_PTR_W-1:0] r_rd;
    logic [C_Q_PTR_W:0]   r_count;

    assign o_full  = (r_count == (C_Q_PTR_W+1)'(C_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

// ----- rtl/core/utf8d_back.sv -----
// back end: expands each job into results and holds the output register
module utf8d_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  utf8d_pkg::t_job           i_q_job,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [utf8d_pkg::C_CP_W-1:0] o_code_point,
    output logic                      o_malformed,
    output logic                      o_run_last,
    output logic                      o_string_done,
    output logic                      o_string_ok
);
    import utf8d_pkg::*;

    logic [C_CNT_W-1:0] r_sub;
    logic               r_ok;
    logic               r_valid;
    logic [C_CP_W-1:0]  r_cp;
    logic               r_bad;
    logic               r_last;
    logic               r_done;
    logic               r_ok_out;

    logic               load;
    logic               in_flush;
    logic [C_CNT_W-1:0] total;
    logic               last;
    logic               cur_bad;
    logic [C_CP_W-1:0]  cur_cp;
    logic               n_ok;

    assign load     = i_q_valid && (!r_valid || i_ready);
    assign in_flush = (r_sub < i_q_job.flush_cnt);
    assign total    = i_q_job.flush_cnt + C_CNT_W'(i_q_job.has_tail);
    assign last     = ((r_sub + 3'd1) == total);
    assign cur_bad  = in_flush ? 1'b1 : i_q_job.tail_bad;
    assign cur_cp   = in_flush ? C_REPL_CP : i_q_job.tail_cp;
    assign n_ok     = r_ok && !cur_bad;
    assign o_pop    = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= '0;
            r_ok    <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= last ? '0 : r_sub + 3'd1;
                r_ok    <= (last && i_q_job.fin) ? 1'b1 : n_ok;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp     <= cur_cp;
            r_bad    <= cur_bad;
            r_last   <= last;
            r_done   <= last && i_q_job.fin;
            r_ok_out <= n_ok;
        end
    end

    assign o_valid       = r_valid;
    assign o_code_point  = r_cp;
    assign o_malformed   = r_bad;
    assign o_run_last    = r_last;
    assign o_string_done = r_done;
    assign o_string_ok   = r_ok_out;

`ifndef ASSERT_OFF
    a_bad_is_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_malformed) |-> (o_code_point == C_REPL_CP && !o_string_ok))
        else $error("malformed result without replacement or with ok flag");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_done) |-> o_run_last)
        else $error("string end not on last result of its byte");
    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_sub < total))
        else $error("result index ran past job size");
`endif

endmodule

// ----- rtl/core/utf8_stream_decoder.sv -----
// top level of the streaming utf-8 decoder with validation
//
// input channel (s side): one raw byte per transaction in tdata, tlast marks
// the last byte of a string. output channel (m side): one decoded code point
// per transaction. a byte gives zero to four results: plain ascii and the
// byte that completes a sequence give one, a byte that only extends a pending
// sequence gives none, errors give U+FFFD replacements marked malformed.
// tuser carries the malformed flag, tlast marks the final result of a string,
// and tdata also carries the per-byte last flag and the sticky string_ok flag.
// a result passes through the job queue and then the output register before
// it shows on the m side.
// throughput: one byte per cycle while each byte gives at most one result and
// the receiver is ready; the result sequencer emits one result per cycle while
// the receiver is ready, so bytes that give more than one result hold the input
// once the 4-entry job queue between the byte decoder and the sequencer fills.
// the output register accepts a new result in the same cycle the old one is
// taken; a stalled receiver backs up into the queue, then into o_s_tready.
// reset (synchronous, active low) clears any pending sequence, empties the
// queue and output register and sets the running string_ok flag back to one.
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // final_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [20:0] code_point, [21] run_last, [22] string_ok, [23] zero
    output logic        o_m_tuser,   // [0] malformed
    output logic        o_m_tlast    // string_done
);
    import utf8d_pkg::*;

    // front to queue
    logic              push;
    t_job              push_job;
    logic              q_full;
    // queue to back
    logic              q_valid;
    t_job              q_job;
    logic              pop;
    // result fields
    logic [C_CP_W-1:0] code_point;
    logic              malformed;
    logic              run_last;
    logic              string_done;
    logic              string_ok;

    // byte classification and sequence tracking
    utf8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_final (i_s_tlast),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // decouples byte intake from result emission
    utf8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // one result per cycle into the output register while it is free or being emptied
    utf8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (q_job),
        .o_pop         (pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_code_point  (code_point),
        .o_malformed   (malformed),
        .o_run_last    (run_last),
        .o_string_done (string_done),
        .o_string_ok   (string_ok)
    );

    assign o_m_tdata = {1'b0, string_ok, run_last, code_point};
    assign o_m_tuser = malformed;
    assign o_m_tlast = string_done;

endmodule
